// File: design/pushdown_automaton_engine_assert.svh
// assertion macros shared by the pushdown automaton engine rtl
`ifndef PUSHDOWN_AUTOMATON_ENGINE_ASSERT_SVH
`define PUSHDOWN_AUTOMATON_ENGINE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define PAE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define PAE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/pae_pkg.sv
// shared types and constants of the pushdown automaton engine
package pae_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;
  localparam int STACK_DEPTH_DEF   = 64;

  localparam int STATE_W   = 4;
  localparam int SYM_W     = 8;
  localparam int KEY_W     = STATE_W + 2 * SYM_W;
  localparam int TRANS_W   = STATE_W + 1 + SYM_W;
  localparam int ENTRY_W   = KEY_W + TRANS_W;
  localparam int OUT_DEPTH_W = 7;

  localparam logic [SYM_W-1:0] EPS_SYM = 8'h30;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_FEED = 1'b1;

  localparam logic [1:0] CFG_START_STATE = 2'd0;
  localparam logic [1:0] CFG_INIT_SYM    = 2'd1;
  localparam logic [1:0] CFG_ACCEPT_MASK = 2'd2;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_TRANS   = 2'd1,
    ST_OVERFLOW   = 2'd2,
    ST_TABLE_FULL = 2'd3
  } status_t;

  typedef struct packed {
    logic [STATE_W-1:0] from_state;
    logic [SYM_W-1:0]   symbol;
    logic [SYM_W-1:0]   top_symbol;
  } key_t;

  typedef struct packed {
    logic [STATE_W-1:0] to_state;
    logic               pop;
    logic [SYM_W-1:0]   push_symbol;
  } trans_t;

  // input tdata, last field in the lowest bits
  typedef struct packed {
    logic [SYM_W-1:0]   push_symbol;
    logic [SYM_W-1:0]   pop_symbol;
    logic [STATE_W-1:0] to_state;
    logic [SYM_W-1:0]   top_symbol;
    logic [SYM_W-1:0]   symbol;
    logic [STATE_W-1:0] from_state;
  } in_word_t;

  // output tdata, last field in the lowest bits
  typedef struct packed {
    logic [OUT_DEPTH_W-1:0] stack_depth;
    logic [STATE_W-1:0]     end_state;
    status_t                status;
    logic                   by_empty_stack;
    logic                   by_final_state;
    logic                   accepted;
  } out_word_t;

  typedef struct packed {
    logic done;
    logic hit;
    logic free;
  } tbl_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD_WAIT,
    S_STEP_GO,
    S_STEP_WAIT,
    S_TOP_FETCH,
    S_EPS_GO,
    S_EPS_WAIT,
    S_FINISH
  } fsm_t;

endpackage

// File: design/pushdown_automaton_engine.sv
// pushdown automaton engine top level: sequencer, stack control, result register
//
//  channel  direction  carries
//  in_      slave      load transition (tuser 0) or feed symbol (tuser 1), tlast ends a string
//  out_     master     one result per input transfer, tlast marks the verdict
//  cfg_     write      start state, initial stack symbol, accept mask
//
// every lookup scans the table memory one entry per cycle from the scan start: a miss
// reads the whole table, a hit stops early; a load takes one scan, a feed of a string not yet
// rejected one scan and, if that step succeeds, a second scan for the epsilon step on its last symbol
// in_tready is high only in the idle state; a finished result waits in the output
// register while the next transfer is taken, and the block holds at the end of an item
// only while that register is still full
// reset clears the table valid bits at once: no clearing pass
`include "pushdown_automaton_engine_assert.svh"
module pushdown_automaton_engine #(
  parameter int TABLE_ENTRIES = pae_pkg::TABLE_ENTRIES_DEF,
  parameter int STACK_DEPTH   = pae_pkg::STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // from_state[3:0] symbol[11:4] top_symbol[19:12] to_state[23:20]
  // pop_symbol[31:24] push_symbol[39:32]
  input  logic [39:0] in_tdata,
  input  logic        in_tuser,   // command
  input  logic        in_tlast,   // last
  output logic        out_tvalid,
  input  logic        out_tready,
  // accepted[0] by_final_state[1] by_empty_stack[2] status[4:3]
  // end_state[8:5] stack_depth[15:9]
  output logic [15:0] out_tdata,
  output logic        out_tlast,  // done_res
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import pae_pkg::*;

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam logic [DW-1:0] DEPTH_MAX = DW'(STACK_DEPTH);

  fsm_t state_r, state_nxt;

  logic [STATE_W-1:0] start_state_r;
  logic [SYM_W-1:0]   init_sym_r;
  logic [15:0]        accept_mask_r;

  logic               cmd_r, last_r;
  logic [SYM_W-1:0]   sym_r;
  key_t               ld_key_r;
  trans_t             ld_trans_r;
  status_t            load_status_r;

  logic [STATE_W-1:0] cur_state_r;
  logic [DW-1:0]      depth_r;
  logic [SYM_W-1:0]   top_r, bottom_r;
  logic               string_start_r;
  status_t            reject_r;

  logic               out_tvalid_r, out_tlast_r;
  out_word_t          out_word_r, out_word;

  in_word_t           in_word;
  logic               in_xfer, out_free;

  logic               scan_start;
  key_t               scan_key;
  logic               tbl_wr_en;
  logic [IW-1:0]      tbl_wr_idx;
  tbl_stat_t          tbl_stat;
  logic [IW-1:0]      hit_idx, free_idx;
  trans_t             hit_trans;

  logic               stk_we;
  logic [AW-1:0]      stk_waddr, stk_raddr;
  logic [SYM_W-1:0]   stk_wdata, stk_rdata;

  logic [SYM_W-1:0]   top_sym;
  logic [DW-1:0]      nd;
  logic               pushes, overflow, done_res, verdict_ok, fin, emp;

  logic               scan_wait, out_full, out_reject, feed_xfer;

  assign in_word   = in_word_t'(in_tdata);
  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;

  // an empty stack shows the epsilon marker on top
  assign top_sym  = (depth_r == '0) ? EPS_SYM : top_r;
  assign nd       = (hit_trans.pop && depth_r != '0) ? depth_r - DW'(1) : depth_r;
  assign pushes   = (hit_trans.push_symbol != EPS_SYM);
  assign overflow = pushes && (nd >= DEPTH_MAX);

  pae_table #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_table (
    .clk        (clk),
    .rst_n      (rst_n),
    .scan_start (scan_start),
    .scan_key   (scan_key),
    .wr_en      (tbl_wr_en),
    .wr_idx     (tbl_wr_idx),
    .wr_key     (ld_key_r),
    .wr_trans   (ld_trans_r),
    .stat       (tbl_stat),
    .hit_idx    (hit_idx),
    .free_idx   (free_idx),
    .hit_trans  (hit_trans)
  );

  pae_stack #(.STACK_DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  always_comb begin
    state_nxt  = state_r;
    scan_start = 1'b0;
    scan_key   = '{from_state: cur_state_r, symbol: sym_r, top_symbol: top_sym};
    tbl_wr_en  = 1'b0;
    tbl_wr_idx = tbl_stat.hit ? hit_idx : free_idx;
    stk_we     = 1'b0;
    stk_waddr  = AW'(nd);
    stk_wdata  = hit_trans.push_symbol;
    stk_raddr  = AW'(nd - DW'(1));
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_tuser == CMD_LOAD) begin
            scan_start = 1'b1;
            scan_key   = '{from_state: in_word.from_state, symbol: in_word.symbol,
                           top_symbol: in_word.top_symbol};
            state_nxt  = S_LOAD_WAIT;
          end else begin
            if (string_start_r) begin
              stk_we    = 1'b1;
              stk_waddr = '0;
              stk_wdata = init_sym_r;
            end
            state_nxt = S_STEP_GO;
          end
        end
      end
      S_LOAD_WAIT: begin
        if (tbl_stat.done) begin
          tbl_wr_en = tbl_stat.hit || tbl_stat.free;
          state_nxt = S_FINISH;
        end
      end
      S_STEP_GO: begin
        if (reject_r == ST_OK) begin
          scan_start = 1'b1;
          state_nxt  = S_STEP_WAIT;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_STEP_WAIT: begin
        if (tbl_stat.done) begin
          if (!tbl_stat.hit || overflow) begin
            state_nxt = S_FINISH;
          end else if (pushes) begin
            stk_we    = 1'b1;
            state_nxt = last_r ? S_EPS_GO : S_FINISH;
          end else if (hit_trans.pop && nd != '0) begin
            // popped without push: fetch the new top
            state_nxt = S_TOP_FETCH;
          end else begin
            state_nxt = last_r ? S_EPS_GO : S_FINISH;
          end
        end
      end
      S_TOP_FETCH: begin
        state_nxt = last_r ? S_EPS_GO : S_FINISH;
      end
      S_EPS_GO: begin
        scan_start = 1'b1;
        scan_key   = '{from_state: cur_state_r, symbol: EPS_SYM, top_symbol: top_sym};
        state_nxt  = S_EPS_WAIT;
      end
      S_EPS_WAIT: begin
        if (tbl_stat.done) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_state_r <= '0;
      init_sym_r    <= 8'd90;
      accept_mask_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_STATE: start_state_r <= cfg_wdata[STATE_W-1:0];
        CFG_INIT_SYM:    init_sym_r    <= cfg_wdata[SYM_W-1:0];
        CFG_ACCEPT_MASK: accept_mask_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_r      <= in_tuser;
      last_r     <= in_tlast;
      sym_r      <= in_word.symbol;
      ld_key_r   <= '{from_state: in_word.from_state, symbol: in_word.symbol,
                      top_symbol: in_word.top_symbol};
      ld_trans_r <= '{to_state: in_word.to_state,
                      pop: (in_word.pop_symbol != EPS_SYM),
                      push_symbol: in_word.push_symbol};
    end
    if (state_r == S_LOAD_WAIT && tbl_stat.done) begin
      load_status_r <= (tbl_stat.hit || tbl_stat.free) ? ST_OK : ST_TABLE_FULL;
    end
  end

  // automaton state, depth, string start flag and reject status; cached top and bottom symbols below
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_state_r    <= '0;
      depth_r        <= '0;
      string_start_r <= 1'b1;
      reject_r       <= ST_OK;
    end else begin
      priority case (state_r)
        S_IDLE: begin
          if (in_xfer && in_tuser == CMD_FEED && string_start_r) begin
            cur_state_r    <= start_state_r;
            depth_r        <= DW'(1);
            reject_r       <= ST_OK;
            string_start_r <= 1'b0;
          end
        end
        S_STEP_WAIT: begin
          if (tbl_stat.done) begin
            if (!tbl_stat.hit) begin
              reject_r <= ST_NO_TRANS;
            end else if (overflow) begin
              reject_r <= ST_OVERFLOW;
            end else begin
              depth_r     <= pushes ? nd + DW'(1) : nd;
              cur_state_r <= hit_trans.to_state;
            end
          end
        end
        S_EPS_WAIT: begin
          if (tbl_stat.done && tbl_stat.hit) begin
            depth_r     <= nd;
            cur_state_r <= hit_trans.to_state;
          end
        end
        S_FINISH: begin
          if (out_free && cmd_r == CMD_FEED && last_r) begin
            string_start_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_xfer && in_tuser == CMD_FEED && string_start_r) begin
      top_r    <= init_sym_r;
      bottom_r <= init_sym_r;
    end else if (state_r == S_STEP_WAIT && tbl_stat.done && tbl_stat.hit && !overflow &&
                 pushes) begin
      top_r <= hit_trans.push_symbol;
      if (nd == '0) begin
        bottom_r <= hit_trans.push_symbol;
      end
    end else if (state_r == S_TOP_FETCH) begin
      top_r <= stk_rdata;
    end
  end

  // result
  assign done_res   = (cmd_r == CMD_FEED) && last_r;
  assign verdict_ok = done_res && (reject_r == ST_OK);
  assign fin        = verdict_ok && accept_mask_r[cur_state_r];
  assign emp        = verdict_ok && (depth_r == DW'(1)) && (bottom_r == init_sym_r);

  always_comb begin
    out_word.accepted       = fin || emp;
    out_word.by_final_state = fin;
    out_word.by_empty_stack = emp;
    out_word.status         = (cmd_r == CMD_LOAD) ? load_status_r : reject_r;
    out_word.end_state      = cur_state_r;
    out_word.stack_depth    = OUT_DEPTH_W'(depth_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (state_r == S_FINISH && out_free) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FINISH && out_free) begin
      out_word_r  <= out_word;
      out_tlast_r <= done_res;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_word_r;
  assign out_tlast  = out_tlast_r;

  assign scan_wait  = (state_r == S_LOAD_WAIT) || (state_r == S_STEP_WAIT) ||
                      (state_r == S_EPS_WAIT);
  assign out_full   = out_tvalid_r && (out_word_r.status == ST_TABLE_FULL);
  assign out_reject = out_tvalid_r && (out_word_r.status != ST_OK);
  assign feed_xfer  = in_xfer && (in_tuser == CMD_FEED);

  `PAE_ASSERT_IMP(a_depth_bound, 1'b1, depth_r <= DEPTH_MAX, "stack depth above capacity")
  `PAE_ASSERT_IMP(a_scan_done_in_wait, tbl_stat.done, scan_wait, "scan done outside a wait state")
  `PAE_ASSERT_IMP(a_full_only_on_load, out_full, !out_tlast_r, "table full with a verdict")
  `PAE_ASSERT_IMP(a_reject_not_accepted, out_reject, !out_word_r.accepted, "rejected string accepted")
  `PAE_ASSERT_NXT(a_feed_opens_string, feed_xfer, !string_start_r, "string start left pending")

endmodule

// File: design/pae_table.sv
// transition table memory with a one-entry-per-cycle key search
module pae_table #(
  parameter int TABLE_ENTRIES = pae_pkg::TABLE_ENTRIES_DEF,
  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               scan_start,
  input  pae_pkg::key_t      scan_key,
  input  logic               wr_en,
  input  logic [IW-1:0]      wr_idx,
  input  pae_pkg::key_t      wr_key,
  input  pae_pkg::trans_t    wr_trans,
  output pae_pkg::tbl_stat_t stat,
  output logic [IW-1:0]      hit_idx,
  output logic [IW-1:0]      free_idx,
  output pae_pkg::trans_t    hit_trans
);
  import pae_pkg::*;

  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

  logic [ENTRY_W-1:0]       mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_r;

  logic               scan_on_r, cmp_on_r;
  logic [IW-1:0]      rd_idx_r, cmp_idx_r;
  logic [ENTRY_W-1:0] rd_entry_r;
  logic               rd_valid_r;
  key_t               key_r;
  logic               done_r, hit_r, free_found_r;
  logic [IW-1:0]      hit_idx_r, free_idx_r;
  trans_t             hit_trans_r;
  logic               match;

  assign match = cmp_on_r && rd_valid_r && (key_t'(rd_entry_r[ENTRY_W-1:TRANS_W]) == key_r);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= {wr_key, wr_trans};
    end
    rd_entry_r <= mem[rd_idx_r];
    rd_valid_r <= valid_r[rd_idx_r];
    if (scan_start) begin
      key_r <= scan_key;
    end
    if (match) begin
      hit_idx_r   <= cmp_idx_r;
      hit_trans_r <= trans_t'(rd_entry_r[TRANS_W-1:0]);
    end
    if (cmp_on_r && !rd_valid_r && !free_found_r) begin
      free_idx_r <= cmp_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_idx] <= 1'b1;
    end
  end

  // issue one read per cycle, compare the entry read in the cycle before
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_on_r    <= 1'b0;
      cmp_on_r     <= 1'b0;
      rd_idx_r     <= '0;
      cmp_idx_r    <= '0;
      done_r       <= 1'b0;
      hit_r        <= 1'b0;
      free_found_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (scan_start) begin
        scan_on_r    <= 1'b1;
        cmp_on_r     <= 1'b0;
        rd_idx_r     <= '0;
        free_found_r <= 1'b0;
        hit_r        <= 1'b0;
      end else begin
        cmp_on_r  <= scan_on_r;
        cmp_idx_r <= rd_idx_r;
        if (scan_on_r) begin
          if (rd_idx_r == LAST_IDX) begin
            scan_on_r <= 1'b0;
          end else begin
            rd_idx_r <= rd_idx_r + IW'(1);
          end
        end
        if (match) begin
          done_r    <= 1'b1;
          hit_r     <= 1'b1;
          scan_on_r <= 1'b0;
          cmp_on_r  <= 1'b0;
        end else if (cmp_on_r) begin
          if (!rd_valid_r) begin
            free_found_r <= 1'b1;
          end
          if (cmp_idx_r == LAST_IDX) begin
            done_r <= 1'b1;
            hit_r  <= 1'b0;
          end
        end
      end
    end
  end

  assign stat.done = done_r;
  assign stat.hit  = hit_r;
  assign stat.free = free_found_r;
  assign hit_idx   = hit_idx_r;
  assign free_idx  = free_idx_r;
  assign hit_trans = hit_trans_r;

endmodule

// File: design/pae_stack.sv
// symbol stack memory, one write and one registered read per cycle
module pae_stack #(
  parameter int STACK_DEPTH = pae_pkg::STACK_DEPTH_DEF,
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [pae_pkg::SYM_W-1:0] wdata,
  input  logic [AW-1:0]             raddr,
  output logic [pae_pkg::SYM_W-1:0] rdata
);
  import pae_pkg::*;

  logic [SYM_W-1:0] mem [STACK_DEPTH];
  logic [SYM_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
